FILE: design/mss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int VAL_W     = 32;
   localparam int POS_W     = 10;
   localparam int CMP_W     = 14;
   // Depth of the split stack: two frames per level plus the root, and three spare entries.
   localparam int STK_D     = 2 * ADDR_W + 4;
   localparam int SP_W      = $clog2(STK_D + 1);
   localparam int IDX_W     = $clog2(STK_D);

   typedef struct packed {
      logic             load;
      logic             read;
      logic             sort_done;
      logic             merge_init;
      logic             merge_read;
      logic             merge_write;
      logic             copy_init;
      logic             copy_step;
      logic             rsp_load;
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] n;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] item_count;
      logic             merge_left;
      logic             copy_done;
      logic             rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/merge_sort_with_comparison_count.sv
`timescale 1ns / 1ps
`default_nettype none
// A load item is taken whenever the controller is idle and no result waits on rsp_tready.
// The item marked last starts the sort: merge passes (a read state and a write state per
// element, through the two-port read of the data store), each with a one-element-a-cycle copy
// back from scratch. A read item's result comes from a registered store read, then goes to the
// result registers. Reset (synchronous, active high) empties the set and clears the internal
// flags and counts; result fields and value stores keep their contents and need no clearing pass.

module merge_sort_with_comparison_count (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [0:0]  req_tuser,   // action[0]
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // sorted_value[31:0], position[41:32], comparisons[55:42]
   output logic [1:0]       rsp_tuser,   // empty_res[0], dropped[1]
   output logic             rsp_tlast    // final_res
);

   mss_pkg::cmd_type  cmd;
   mss_pkg::stat_type stat;

   logic signed [mss_pkg::VAL_W-1:0] rsp_value;
   logic [mss_pkg::POS_W-1:0]        rsp_position;
   logic [mss_pkg::CMP_W-1:0]        rsp_comparisons;
   logic                             rsp_empty, rsp_dropped, rsp_final;

   // The controller walks the split stack and sequences every merge and copy pass.
   mss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds both stores, the merge pointers, the counters and the result register.
   mss_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_tdata),
      .req_last        (req_tlast),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_value       (rsp_value),
      .rsp_position    (rsp_position),
      .rsp_final       (rsp_final),
      .rsp_empty       (rsp_empty),
      .rsp_comparisons (rsp_comparisons),
      .rsp_dropped     (rsp_dropped)
   );

   // Results are packed from the lowest bit up, as listed beside the ports.
   assign rsp_tdata = {rsp_comparisons, rsp_position, rsp_value};
   assign rsp_tuser = {rsp_dropped, rsp_empty};
   assign rsp_tlast = rsp_final;

endmodule

`default_nettype wire

FILE: design/mss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_action,
   input  wire logic             req_last,
   output logic                  req_tready,
   output mss_pkg::cmd_type      cmd,
   input  wire mss_pkg::stat_type stat
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_MRD   = 3'd4;
   localparam logic [2:0] S_MWR   = 3'd5;
   localparam logic [2:0] S_COPY  = 3'd6;

   typedef struct packed {
      logic [mss_pkg::CNT_W-1:0] lo;
      logic [mss_pkg::CNT_W-1:0] n;
      logic                      seen;
   } frame_type;

   logic [2:0]                state_ff, state_in;
   logic [mss_pkg::SP_W-1:0]  sp_ff, sp_in;
   frame_type                 stk_ff [mss_pkg::STK_D];

   logic [mss_pkg::SP_W-1:0]  sp_m1, sp_p1;
   logic [mss_pkg::IDX_W-1:0] top_idx;
   frame_type                 top;
   logic [mss_pkg::CNT_W-1:0] half;
   logic                      accept, push_root, expand;

   assign sp_m1   = sp_ff - mss_pkg::SP_W'(1);
   assign sp_p1   = sp_ff + mss_pkg::SP_W'(1);
   assign top_idx = sp_m1[mss_pkg::IDX_W-1:0];
   assign top     = stk_ff[top_idx];
   assign half    = top.n >> 1;

   assign req_tready = (state_ff == S_IDLE) && !stat.rsp_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      push_root = 1'b0;
      expand    = 1'b0;
      cmd       = '0;
      cmd.lo    = top.lo;
      cmd.n     = top.n;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action) begin
                  cmd.read = 1'b1;
                  state_in = S_READ;
               end else begin
                  cmd.load = 1'b1;
                  if (req_last) state_in = S_START;
               end
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         S_START: begin
            push_root = 1'b1;
            sp_in     = mss_pkg::SP_W'(1);
            state_in  = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               cmd.sort_done = 1'b1;
               state_in      = S_IDLE;
            end else if (top.n < mss_pkg::CNT_W'(2)) begin
               sp_in = sp_m1;
            end else if (!top.seen) begin
               expand = 1'b1;
               sp_in  = sp_p1 + mss_pkg::SP_W'(1);
            end else begin
               sp_in          = sp_m1;
               cmd.merge_init = 1'b1;
               state_in       = S_MRD;
            end
         end
         S_MRD: begin
            if (stat.merge_left) begin
               cmd.merge_read = 1'b1;
               state_in       = S_MWR;
            end else begin
               cmd.copy_init = 1'b1;
               state_in      = S_COPY;
            end
         end
         S_MWR: begin
            cmd.merge_write = 1'b1;
            state_in        = S_MRD;
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.copy_done) state_in = S_POP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
      end
   end

   // Frames carry no reset; only entries below the stack pointer are read.
   always_ff @(posedge clock) begin
      if (push_root) begin
         stk_ff[0] <= '{lo: '0, n: stat.item_count, seen: 1'b0};
      end
      if (expand) begin
         stk_ff[top_idx]                    <= '{lo: top.lo, n: top.n, seen: 1'b1};
         stk_ff[sp_ff[mss_pkg::IDX_W-1:0]]  <= '{lo: top.lo + half, n: top.n - half,
                                                seen: 1'b0};
         stk_ff[sp_p1[mss_pkg::IDX_W-1:0]]  <= '{lo: top.lo, n: half, seen: 1'b0};
      end
   end

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= mss_pkg::SP_W'(mss_pkg::STK_D))
      else $error("split stack overflow");

   a_merge_size: assert property (@(posedge clock) disable iff (reset)
      cmd.merge_init |-> (cmd.n >= mss_pkg::CNT_W'(2)))
      else $error("merge issued on a run shorter than two");

endmodule

`default_nettype wire

FILE: design/mss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mss_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [mss_pkg::VAL_W-1:0] req_value,
   input  wire logic                          req_last,
   input  wire mss_pkg::cmd_type              cmd,
   output mss_pkg::stat_type                  stat,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic signed [mss_pkg::VAL_W-1:0]   rsp_value,
   output logic [mss_pkg::POS_W-1:0]          rsp_position,
   output logic                               rsp_final,
   output logic                               rsp_empty,
   output logic [mss_pkg::CMP_W-1:0]          rsp_comparisons,
   output logic                               rsp_dropped
);

   localparam int AW = mss_pkg::ADDR_W;
   localparam int CW = mss_pkg::CNT_W;
   localparam int VW = mss_pkg::VAL_W;

   logic signed [VW-1:0] data_mem    [mss_pkg::MAX_ITEMS];
   logic signed [VW-1:0] scratch_mem [mss_pkg::MAX_ITEMS];

   logic [CW-1:0] count_ff, rdp_ff;
   logic [mss_pkg::CMP_W-1:0] cmp_ff;
   logic          sorted_ff, ovf_ff;
   logic [CW-1:0] a_ff, b_ff, aend_ff, bend_ff, k_ff, lo_ff, end_ff, c_ff, cw_ff;
   logic          copy_vld_ff, rd_ok_ff, rsp_valid_ff;
   logic [CW-1:0] rd_pos_ff;
   logic signed [VW-1:0] qa_ff, qb_ff, sq_ff;

   logic [CW-1:0] cnt_eff, half, addr_a, waddr;
   logic          room, a_has, b_has, take_a, dwe, copy_rd, rd_ok;
   logic signed [VW-1:0] wdata;

   assign cnt_eff = sorted_ff ? '0 : count_ff;
   assign room    = cnt_eff < CW'(mss_pkg::MAX_ITEMS);
   assign half    = cmd.n >> 1;
   assign a_has   = a_ff < aend_ff;
   assign b_has   = b_ff < bend_ff;
   assign take_a  = a_has && (!b_has || (qa_ff < qb_ff));
   assign copy_rd = cmd.copy_step && (c_ff < end_ff);
   assign rd_ok   = sorted_ff && (rdp_ff < count_ff);

   assign dwe    = (cmd.load && room) || copy_vld_ff;
   assign waddr  = copy_vld_ff ? cw_ff : cnt_eff;
   assign wdata  = copy_vld_ff ? sq_ff : req_value;
   assign addr_a = cmd.merge_read ? a_ff : rdp_ff;

   always_ff @(posedge clock) begin
      if (dwe) data_mem[waddr[AW-1:0]] <= wdata;
      if (cmd.merge_read || cmd.read) qa_ff <= data_mem[addr_a[AW-1:0]];
      if (cmd.merge_read) qb_ff <= data_mem[b_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_write) scratch_mem[k_ff[AW-1:0]] <= take_a ? qa_ff : qb_ff;
      if (copy_rd) sq_ff <= scratch_mem[c_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_init) begin
         a_ff    <= cmd.lo;
         aend_ff <= cmd.lo + half;
         b_ff    <= cmd.lo + half;
         bend_ff <= cmd.lo + cmd.n;
         k_ff    <= cmd.lo;
         lo_ff   <= cmd.lo;
         end_ff  <= cmd.lo + cmd.n;
      end
      if (cmd.merge_write) begin
         k_ff <= k_ff + CW'(1);
         if (take_a) a_ff <= a_ff + CW'(1);
         else        b_ff <= b_ff + CW'(1);
      end
      if (cmd.copy_init) c_ff <= lo_ff;
      else if (copy_rd) c_ff <= c_ff + CW'(1);
      cw_ff <= c_ff;
      if (cmd.read) rd_pos_ff <= rdp_ff;
      if (cmd.rsp_load) begin
         rsp_value       <= rd_ok_ff ? qa_ff : '0;
         rsp_position    <= rd_ok_ff ? mss_pkg::POS_W'(rd_pos_ff) : '0;
         rsp_final       <= rd_ok_ff && (rd_pos_ff + CW'(1) == count_ff);
         rsp_empty       <= !rd_ok_ff;
         rsp_comparisons <= cmp_ff;
         rsp_dropped     <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_ff       <= '0;
         rdp_ff       <= '0;
         sorted_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         copy_vld_ff  <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         copy_vld_ff <= copy_rd;
         if (cmd.load) begin
            sorted_ff <= 1'b0;
            if (sorted_ff) rdp_ff <= '0;
            if (sorted_ff || req_last) cmp_ff <= '0;
            if (room) count_ff <= cnt_eff + CW'(1);
            else      count_ff <= cnt_eff;
            ovf_ff <= (ovf_ff && !sorted_ff) || !room;
         end
         if (cmd.merge_write && a_has && b_has && (cmp_ff != '1)) begin
            cmp_ff <= cmp_ff + mss_pkg::CMP_W'(1);
         end
         if (cmd.sort_done) begin
            sorted_ff <= 1'b1;
            rdp_ff    <= '0;
         end
         if (cmd.read) begin
            rd_ok_ff <= rd_ok;
            if (rd_ok) rdp_ff <= rdp_ff + CW'(1);
         end
         if (cmd.rsp_load)                     rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)  rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign stat.item_count = count_ff;
   assign stat.merge_left = a_has || b_has;
   assign stat.copy_done  = (c_ff >= end_ff) && !copy_vld_ff;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mss_pkg::MAX_ITEMS))
      else $error("item count beyond capacity");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty && rsp_final))
      else $error("result marked both empty and final");

endmodule

`default_nettype wire
